// ===== src/kf2_pkg.sv =====
// Package for the two-state angle/rate Kalman filter.
// Holds fixed-point widths, register codes, state types and the micro-op table.
// No dependencies; imported by kf2_div and kalman_filter_two_state.
`default_nettype none

package kf2_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int TS_W       = 17;
    localparam int NOISE_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Fixed-point one, and register reset values
    localparam logic [DATA_W-1:0]  FX_ONE        = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [TS_W-1:0]    TS_RST        = TS_W'(655);
    localparam logic [NOISE_W-1:0] ANGLE_NZ_RST  = NOISE_W'(66);
    localparam logic [NOISE_W-1:0] BIAS_NZ_RST   = NOISE_W'(197);
    localparam logic [NOISE_W-1:0] MEAS_NZ_RST   = NOISE_W'(19661);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP,
        REG_ANGLE_NOISE,
        REG_BIAS_NOISE,
        REG_MEAS_NOISE
    } t_reg_idx;

    // Operand sources of the shared multiply-accumulate unit
    typedef enum logic [4:0] {
        OPD_X0, OPD_X1,
        OPD_P00, OPD_P01, OPD_P10, OPD_P11,
        OPD_S00, OPD_S11, OPD_TA, OPD_T,
        OPD_Z0, OPD_Z1, OPD_Y0, OPD_Y1,
        OPD_K00, OPD_K01, OPD_K10, OPD_K11,
        OPD_DT, OPD_AN, OPD_BN, OPD_MN, OPD_ONE
    } t_opnd;

    // Write-back destinations
    typedef enum logic [4:0] {
        DST_X0, DST_X1,
        DST_P00, DST_P01, DST_P10, DST_P11,
        DST_S00, DST_S11, DST_TA, DST_T,
        DST_Y0, DST_Y1,
        DST_K00, DST_K01, DST_K10, DST_K11,
        DST_DET
    } t_dst;

    // Micro-op kinds: rounded dot product, determinant, gain division
    typedef enum logic [1:0] {
        KIND_DOT,
        KIND_DET,
        KIND_GAIN
    } t_kind;

    // One micro-op: dst <= A*B +/- C*D
    typedef struct packed {
        t_opnd a;
        t_opnd b;
        t_opnd c;
        t_opnd d;
        logic  sub;
        t_dst  dst;
        t_kind kind;
    } t_uop;

    localparam int NUM_UOPS = 28;
    localparam int UOP_W    = $clog2(NUM_UOPS);
    localparam logic [UOP_W-1:0] UOP_LAST = UOP_W'(NUM_UOPS - 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_AB,
        ST_MUL_CD,
        ST_ACC,
        ST_WB,
        ST_DIV,
        ST_FIN
    } t_kf_st;

    // Divider states
    typedef enum logic [2:0] {
        DV_IDLE,
        DV_CHK,
        DV_RUN,
        DV_RND,
        DV_OUT
    } t_div_st;

    // Micro-op program: predict, determinant, gains, state update, covariance update
    function automatic t_uop kf2_uop(input logic [UOP_W-1:0] idx);
        t_uop u;
        case (idx)
            // predict
            5'd0:  u = '{OPD_X0,  OPD_ONE, OPD_DT,  OPD_X1,  1'b0, DST_X0,  KIND_DOT};
            5'd1:  u = '{OPD_P00, OPD_ONE, OPD_DT,  OPD_P10, 1'b0, DST_TA,  KIND_DOT};
            5'd2:  u = '{OPD_P01, OPD_ONE, OPD_DT,  OPD_P11, 1'b0, DST_P01, KIND_DOT};
            5'd3:  u = '{OPD_TA,  OPD_ONE, OPD_DT,  OPD_P01, 1'b0, DST_TA,  KIND_DOT};
            5'd4:  u = '{OPD_TA,  OPD_ONE, OPD_AN,  OPD_ONE, 1'b0, DST_P00, KIND_DOT};
            5'd5:  u = '{OPD_P10, OPD_ONE, OPD_DT,  OPD_P11, 1'b0, DST_P10, KIND_DOT};
            5'd6:  u = '{OPD_P11, OPD_ONE, OPD_BN,  OPD_ONE, 1'b0, DST_P11, KIND_DOT};
            // innovation covariance and its determinant
            5'd7:  u = '{OPD_P00, OPD_ONE, OPD_MN,  OPD_ONE, 1'b0, DST_S00, KIND_DOT};
            5'd8:  u = '{OPD_P11, OPD_ONE, OPD_MN,  OPD_ONE, 1'b0, DST_S11, KIND_DOT};
            5'd9:  u = '{OPD_S00, OPD_S11, OPD_P01, OPD_P10, 1'b1, DST_DET, KIND_DET};
            // gains: (P adj(S)) / det
            5'd10: u = '{OPD_P00, OPD_S11, OPD_P01, OPD_P10, 1'b1, DST_K00, KIND_GAIN};
            5'd11: u = '{OPD_P01, OPD_S00, OPD_P00, OPD_P01, 1'b1, DST_K01, KIND_GAIN};
            5'd12: u = '{OPD_P10, OPD_S11, OPD_P11, OPD_P10, 1'b1, DST_K10, KIND_GAIN};
            5'd13: u = '{OPD_P11, OPD_S00, OPD_P10, OPD_P01, 1'b1, DST_K11, KIND_GAIN};
            // innovations and state update
            5'd14: u = '{OPD_Z0,  OPD_ONE, OPD_X0,  OPD_ONE, 1'b1, DST_Y0,  KIND_DOT};
            5'd15: u = '{OPD_Z1,  OPD_ONE, OPD_X1,  OPD_ONE, 1'b1, DST_Y1,  KIND_DOT};
            5'd16: u = '{OPD_K00, OPD_Y0,  OPD_K01, OPD_Y1,  1'b0, DST_T,   KIND_DOT};
            5'd17: u = '{OPD_X0,  OPD_ONE, OPD_T,   OPD_ONE, 1'b0, DST_X0,  KIND_DOT};
            5'd18: u = '{OPD_K10, OPD_Y0,  OPD_K11, OPD_Y1,  1'b0, DST_T,   KIND_DOT};
            5'd19: u = '{OPD_X1,  OPD_ONE, OPD_T,   OPD_ONE, 1'b0, DST_X1,  KIND_DOT};
            // covariance update; new P00/P01 parked in S00/S11 until the end
            5'd20: u = '{OPD_K00, OPD_P00, OPD_K01, OPD_P10, 1'b0, DST_T,   KIND_DOT};
            5'd21: u = '{OPD_P00, OPD_ONE, OPD_T,   OPD_ONE, 1'b1, DST_S00, KIND_DOT};
            5'd22: u = '{OPD_K00, OPD_P01, OPD_K01, OPD_P11, 1'b0, DST_T,   KIND_DOT};
            5'd23: u = '{OPD_P01, OPD_ONE, OPD_T,   OPD_ONE, 1'b1, DST_S11, KIND_DOT};
            5'd24: u = '{OPD_K10, OPD_P00, OPD_K11, OPD_P10, 1'b0, DST_T,   KIND_DOT};
            5'd25: u = '{OPD_P10, OPD_ONE, OPD_T,   OPD_ONE, 1'b1, DST_P10, KIND_DOT};
            5'd26: u = '{OPD_K10, OPD_P01, OPD_K11, OPD_P11, 1'b0, DST_T,   KIND_DOT};
            5'd27: u = '{OPD_P11, OPD_ONE, OPD_T,   OPD_ONE, 1'b1, DST_P11, KIND_DOT};
            default: u = '{OPD_ONE, OPD_ONE, OPD_ONE, OPD_ONE, 1'b0, DST_T, KIND_DOT};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== src/kf2_div.sv =====
// Radix-2 restoring divider for the Kalman gains: round(num * 2^FRAC_BITS / den).
// Rounds to nearest with ties away from zero and saturates to 32 bits.
// Depends on kf2_pkg.
`default_nettype none

module kf2_div
    import kf2_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [PROD_W-1:0]  i_num,
    input  wire logic signed [PROD_W-1:0]  i_den,
    output logic                           o_done,
    output logic signed [DATA_W-1:0]       o_quot
);

    localparam int SH    = DATA_W - FRAC_BITS;
    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [DATA_W:0] MAG_CAP = (DATA_W+1)'(1) << (DATA_W - 1);

    t_div_st r_state, n_state;

    logic [PROD_W-1:0]   r_nm;
    logic [PROD_W-1:0]   r_dm;
    logic                r_neg;
    logic [PROD_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_low;
    logic [DATA_W-1:0]   r_q;
    logic                r_sat;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W:0]     r_mag;
    logic [DATA_W-1:0]   r_quot;
    logic                r_done;

    logic [PROD_W-1:0]   hi_part;
    logic                hi_ovf;
    logic [PROD_W:0]     trial;
    logic                trial_ge;
    logic [PROD_W:0]     trial_diff;
    logic                round_up;
    logic [DATA_W:0]     mag_clamp;

    // Dividend is |num| << FRAC_BITS; its top part decides overflow up front
    always_comb begin
        hi_part    = r_nm >> SH;
        hi_ovf     = (hi_part >= r_dm);
        trial      = {r_rem, r_low[DATA_W-1]};
        trial_ge   = (trial >= {1'b0, r_dm});
        trial_diff = trial - {1'b0, r_dm};
        round_up   = ({r_rem, 1'b0} >= {1'b0, r_dm});
        mag_clamp  = (r_mag > MAG_CAP) ? MAG_CAP : r_mag;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_start) begin
                n_state = DV_CHK;
            end
            DV_CHK:  n_state = hi_ovf ? DV_RND : DV_RUN;
            DV_RUN:  if (r_cnt == CNT_W'(DATA_W - 1)) begin
                n_state = DV_RND;
            end
            DV_RND:  n_state = DV_OUT;
            DV_OUT:  n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    // State and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == DV_OUT);
        end
    end

    // Datapath: take magnitudes, shift-subtract one quotient bit per cycle, round
    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: if (i_start) begin
                r_nm  <= i_num[PROD_W-1] ? PROD_W'(-i_num) : i_num;
                r_dm  <= i_den[PROD_W-1] ? PROD_W'(-i_den) : i_den;
                r_neg <= i_num[PROD_W-1] ^ i_den[PROD_W-1];
            end
            DV_CHK: begin
                r_rem <= hi_part;
                r_low <= DATA_W'(r_nm << FRAC_BITS);
                r_sat <= hi_ovf;
                r_q   <= '0;
                r_cnt <= '0;
            end
            DV_RUN: begin
                r_rem <= trial_ge ? trial_diff[PROD_W-1:0] : trial[PROD_W-1:0];
                r_low <= r_low << 1;
                r_q   <= {r_q[DATA_W-2:0], trial_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            DV_RND: begin
                r_mag <= r_sat ? MAG_CAP : ({1'b0, r_q} + (DATA_W+1)'(round_up));
            end
            DV_OUT: begin
                if (r_neg) begin
                    r_quot <= DATA_W'(-mag_clamp);
                end else if (mag_clamp == MAG_CAP) begin
                    r_quot <= {1'b0, {(DATA_W-1){1'b1}}};
                end else begin
                    r_quot <= mag_clamp[DATA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== src/kalman_filter_two_state.sv =====
// Top level of the two-state (angle, rate) Kalman filter in signed Q16.16.
// Depends on kf2_pkg and kf2_div.
`default_nettype none

// Each accepted sample (angle and rate measurement) runs one predict step with
// F = [1 dt; 0 1] and one update step with H = I, then presents the new angle and
// rate estimates with a singular flag, set when det(S) is zero and the update was
// skipped. All results saturate to 32 bits. A full update runs 28 micro-ops (two
// multiplies, accumulate, write back) on the one shared 32x32 multiplier, and each
// of the four gain divisions runs in a one-bit-per-cycle divider. A division whose
// quotient overflows and saturates skips the bit steps instead. With a zero
// determinant the sequence ends after the determinant micro-op. The input is not
// ready while a sample is in work; a finished result sits in an output register,
// so the next sample may transfer in before the previous result is taken. A
// finished result waits while that register is still full; the input is ready
// again in the cycle after the result is loaded. Configuration writes are meant
// for idle periods.
module kalman_filter_two_state
    import kf2_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [DATA_W-1:0]       i_angle_meas,
    input  wire logic signed [DATA_W-1:0]       i_rate_meas,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [DATA_W-1:0]            o_angle_est,
    output logic signed [DATA_W-1:0]            o_rate_est,
    output logic                                o_singular,
    input  wire logic                           i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int RQ_W = PROD_W - FRAC_BITS + 1;
    localparam logic signed [PROD_W-1:0] MAX64 = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] MIN64 = {1'b1, {(PROD_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration
    logic [TS_W-1:0]    r_time_step;
    logic [NOISE_W-1:0] r_angle_noise;
    logic [NOISE_W-1:0] r_bias_noise;
    logic [NOISE_W-1:0] r_meas_noise;

    // Filter state
    logic signed [DATA_W-1:0] r_x0, r_x1;
    logic signed [DATA_W-1:0] r_p00, r_p01, r_p10, r_p11;

    // Working registers
    logic signed [DATA_W-1:0] r_s00, r_s11, r_ta, r_t;
    logic signed [DATA_W-1:0] r_z0, r_z1, r_y0, r_y1;
    logic signed [DATA_W-1:0] r_k00, r_k01, r_k10, r_k11;
    logic signed [PROD_W-1:0] r_prod, r_acc, r_det;
    logic                     r_sing;

    // Output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_angle, r_out_rate;
    logic                     r_out_sing;

    // Sequencer
    t_kf_st           r_state, n_state;
    logic [UOP_W-1:0] r_op;
    t_uop             uop;

    logic                     in_fire;
    logic                     op_step;
    logic                     wb_en;
    logic                     div_start;
    logic                     out_load;
    logic                     det_zero;
    logic signed [DATA_W-1:0] mul_x, mul_y;
    logic signed [DATA_W-1:0] wb_data;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quot;

    // Operand selection for the shared multiplier
    function automatic logic signed [DATA_W-1:0] opnd(input t_opnd sel);
        logic signed [DATA_W-1:0] v;
        case (sel)
            OPD_X0:  v = r_x0;
            OPD_X1:  v = r_x1;
            OPD_P00: v = r_p00;
            OPD_P01: v = r_p01;
            OPD_P10: v = r_p10;
            OPD_P11: v = r_p11;
            OPD_S00: v = r_s00;
            OPD_S11: v = r_s11;
            OPD_TA:  v = r_ta;
            OPD_T:   v = r_t;
            OPD_Z0:  v = r_z0;
            OPD_Z1:  v = r_z1;
            OPD_Y0:  v = r_y0;
            OPD_Y1:  v = r_y1;
            OPD_K00: v = r_k00;
            OPD_K01: v = r_k01;
            OPD_K10: v = r_k10;
            OPD_K11: v = r_k11;
            OPD_DT:  v = DATA_W'(r_time_step);
            OPD_AN:  v = DATA_W'(r_angle_noise);
            OPD_BN:  v = DATA_W'(r_bias_noise);
            OPD_MN:  v = DATA_W'(r_meas_noise);
            OPD_ONE: v = FX_ONE;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Sum or difference of two products, saturated to 64 bits
    function automatic logic signed [PROD_W-1:0] acc64(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic                     sub
    );
        logic signed [PROD_W:0] s;
        logic signed [PROD_W-1:0] r;
        s = sub ? ({a[PROD_W-1], a} - {b[PROD_W-1], b})
                : ({a[PROD_W-1], a} + {b[PROD_W-1], b});
        if (s[PROD_W] != s[PROD_W-1]) begin
            r = s[PROD_W] ? MIN64 : MAX64;
        end else begin
            r = s[PROD_W-1:0];
        end
        return r;
    endfunction

    // Drop the fraction bits, round half up, saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] rnd32(input logic signed [PROD_W-1:0] x);
        logic [RQ_W-1:0]          q;
        logic                     fits;
        logic signed [DATA_W-1:0] r;
        q    = RQ_W'(x >>> FRAC_BITS) + RQ_W'(x[FRAC_BITS-1]);
        fits = (&q[RQ_W-1:DATA_W-1]) | ~(|q[RQ_W-1:DATA_W-1]);
        if (fits) begin
            r = q[DATA_W-1:0];
        end else begin
            r = q[RQ_W-1] ? MIN32 : MAX32;
        end
        return r;
    endfunction

    assign uop      = kf2_uop(r_op);
    assign det_zero = (r_acc == '0);
    assign in_fire  = i_in_valid && o_in_ready;
    assign wb_data  = (r_state == ST_DIV) ? div_quot : rnd32(r_acc);

    // Multiplier inputs: A*B first, C*D second
    always_comb begin
        if (r_state == ST_MUL_CD) begin
            mul_x = opnd(uop.c);
            mul_y = opnd(uop.d);
        end else begin
            mul_x = opnd(uop.a);
            mul_y = opnd(uop.b);
        end
    end

    // Next state and control
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        op_step    = 1'b0;
        wb_en      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_MUL_AB;
                end
            end
            ST_MUL_AB: n_state = ST_MUL_CD;
            ST_MUL_CD: n_state = ST_ACC;
            ST_ACC:    n_state = ST_WB;
            ST_WB: begin
                case (uop.kind)
                    KIND_DOT: begin
                        wb_en   = 1'b1;
                        op_step = 1'b1;
                        n_state = (r_op == UOP_LAST) ? ST_FIN : ST_MUL_AB;
                    end
                    KIND_DET: begin
                        op_step = !det_zero;
                        n_state = det_zero ? ST_FIN : ST_MUL_AB;
                    end
                    KIND_GAIN: begin
                        div_start = 1'b1;
                        n_state   = ST_DIV;
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_DIV: begin
                if (div_done) begin
                    wb_en   = 1'b1;
                    op_step = 1'b1;
                    n_state = (r_op == UOP_LAST) ? ST_FIN : ST_MUL_AB;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_op          <= '0;
            r_out_valid   <= 1'b0;
            r_time_step   <= TS_RST;
            r_angle_noise <= ANGLE_NZ_RST;
            r_bias_noise  <= BIAS_NZ_RST;
            r_meas_noise  <= MEAS_NZ_RST;
            r_x0          <= '0;
            r_x1          <= '0;
            r_p00         <= FX_ONE;
            r_p01         <= '0;
            r_p10         <= '0;
            r_p11         <= FX_ONE;
        end else begin
            r_state <= n_state;

            // advance the micro-op pointer
            if (in_fire) begin
                r_op <= '0;
            end else if (op_step) begin
                r_op <= r_op + 1'b1;
            end

            // hold the result until transferred out
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // configuration writes
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_TIME_STEP:   r_time_step   <= i_cfg_data[TS_W-1:0];
                    REG_ANGLE_NOISE: r_angle_noise <= i_cfg_data[NOISE_W-1:0];
                    REG_BIAS_NOISE:  r_bias_noise  <= i_cfg_data[NOISE_W-1:0];
                    REG_MEAS_NOISE:  r_meas_noise  <= i_cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end

            // write back state destinations
            if (wb_en) begin
                case (uop.dst)
                    DST_X0:  r_x0  <= wb_data;
                    DST_X1:  r_x1  <= wb_data;
                    DST_P00: r_p00 <= wb_data;
                    DST_P01: r_p01 <= wb_data;
                    DST_P10: r_p10 <= wb_data;
                    DST_P11: r_p11 <= wb_data;
                    default: ;
                endcase
            end

            // commit the parked new P00/P01 after a full update
            if (out_load && !r_sing) begin
                r_p00 <= r_s00;
                r_p01 <= r_s11;
            end
        end
    end

    // Working registers, products and output payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_z0   <= i_angle_meas;
            r_z1   <= i_rate_meas;
            r_sing <= 1'b0;
        end

        case (r_state)
            ST_MUL_AB: r_prod <= mul_x * mul_y;
            ST_MUL_CD: begin
                r_prod <= mul_x * mul_y;
                r_acc  <= r_prod;
            end
            ST_ACC:    r_acc <= acc64(r_acc, r_prod, uop.sub);
            ST_WB: begin
                if (uop.kind == KIND_DET) begin
                    r_det  <= r_acc;
                    r_sing <= det_zero;
                end
            end
            default: ;
        endcase

        if (wb_en) begin
            case (uop.dst)
                DST_S00: r_s00 <= wb_data;
                DST_S11: r_s11 <= wb_data;
                DST_TA:  r_ta  <= wb_data;
                DST_T:   r_t   <= wb_data;
                DST_Y0:  r_y0  <= wb_data;
                DST_Y1:  r_y1  <= wb_data;
                DST_K00: r_k00 <= wb_data;
                DST_K01: r_k01 <= wb_data;
                DST_K10: r_k10 <= wb_data;
                DST_K11: r_k11 <= wb_data;
                default: ;
            endcase
        end

        if (out_load) begin
            r_out_angle <= r_x0;
            r_out_rate  <= r_x1;
            r_out_sing  <= r_sing;
        end
    end

    // Gain divider: numerator from the accumulator, denominator det(S)
    kf2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_angle_est = r_out_angle;
    assign o_rate_est  = r_out_rate;
    assign o_singular  = r_out_sing;

endmodule

`default_nettype wire
